// ----- rtl/isc_pkg.sv -----
// Package for the index/subscript converter.
// Holds shared widths, register codes and defaults; no dependencies.
package isc_pkg;

  localparam int unsigned LIN_W        = 48;  // linear index width
  localparam int unsigned SLOTS        = 4;   // subscript slots on the ports
  localparam int unsigned NDIMS_W      = 3;   // width of the dimension count register
  localparam int unsigned STEP_BITS    = 4;   // quotient bits resolved per divider stage
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned DEF_MAX_DIMS = 4;
  localparam int unsigned DEF_DIM_BITS = 12;

  localparam logic [NDIMS_W-1:0] NUM_DIMS_RST = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS = 3'd0,
    CFG_SIZE0    = 3'd1,
    CFG_SIZE1    = 3'd2,
    CFG_SIZE2    = 3'd3,
    CFG_SIZE3    = 3'd4
  } cfg_reg_e;

endpackage

// ----- rtl/isc_if.sv -----
// Channel interfaces of the index/subscript converter: request, response
// and the internal pipeline stage link. Depends on isc_pkg.
interface isc_req_if #(
  parameter int unsigned DIM_BITS = isc_pkg::DEF_DIM_BITS
);
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [isc_pkg::LIN_W-1:0]  lin_index_in;
  logic [DIM_BITS-1:0]        coord0_in;
  logic [DIM_BITS-1:0]        coord1_in;
  logic [DIM_BITS-1:0]        coord2_in;
  logic [DIM_BITS-1:0]        coord3_in;

  modport source (output valid, req_type, lin_index_in, coord0_in, coord1_in,
                  coord2_in, coord3_in, input ready);
  modport sink   (input valid, req_type, lin_index_in, coord0_in, coord1_in,
                  coord2_in, coord3_in, output ready);
endinterface

interface isc_rsp_if #(
  parameter int unsigned DIM_BITS = isc_pkg::DEF_DIM_BITS
);
  logic                       valid;
  logic                       ready;
  logic [isc_pkg::LIN_W-1:0]  lin_index_out;
  logic [DIM_BITS-1:0]        coord0_out;
  logic [DIM_BITS-1:0]        coord1_out;
  logic [DIM_BITS-1:0]        coord2_out;
  logic [DIM_BITS-1:0]        coord3_out;
  logic                       out_of_range;

  modport source (output valid, lin_index_out, coord0_out, coord1_out, coord2_out,
                  coord3_out, out_of_range, input ready);
  modport sink   (input valid, lin_index_out, coord0_out, coord1_out, coord2_out,
                  coord3_out, out_of_range, output ready);
endinterface

interface isc_stage_if #(
  parameter int unsigned DIM_BITS = isc_pkg::DEF_DIM_BITS
);
  logic                        valid;
  logic                        ready;
  logic                        mode;   // 1: index to subscripts
  logic                        bad;
  logic [isc_pkg::SLOTS-1:0]   used;
  logic [isc_pkg::LIN_W-1:0]   work;   // dividend/quotient, or finished index
  logic [DIM_BITS-1:0]         rem;
  logic [DIM_BITS-1:0]         coord [isc_pkg::SLOTS];

  modport source (output valid, mode, bad, used, work, rem, coord, input ready);
  modport sink   (input valid, mode, bad, used, work, rem, coord, output ready);
endinterface

// ----- rtl/isc_front.sv -----
// Front end of the converter: range checks, element count and the Horner
// sum over four register stages. Depends on isc_pkg and isc_if.
module isc_front #(
  parameter int unsigned DIM_BITS = isc_pkg::DEF_DIM_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [isc_pkg::SLOTS-1:0] used_i,
  input  logic [DIM_BITS-1:0]       size_i [isc_pkg::SLOTS],
  isc_req_if.sink                   req,
  isc_stage_if.source               out
);

  localparam int unsigned DW = DIM_BITS;
  localparam int unsigned W2 = 2 * DW;
  localparam int unsigned W3 = 3 * DW;
  localparam int unsigned W4 = 4 * DW;
  localparam int unsigned LW = isc_pkg::LIN_W;
  localparam int unsigned CW = (W4 > LW) ? W4 : LW;

  logic [3:0] v_q;
  logic [3:0] rdy;

  // stage 1
  logic          mode1_q, bad1_q;
  logic [LW-1:0] idx1_q;
  logic [DW-1:0] c1_q [isc_pkg::SLOTS];
  logic [3:0]    used1_q;
  logic [W2-1:0] p01_q, p23_q;
  // stage 2
  logic          mode2_q, bad2_q;
  logic [LW-1:0] idx2_q;
  logic [DW-1:0] c2_0_q, c2_1_q;
  logic [3:0]    used2_q;
  logic [W2-1:0] acc2_q;
  logic [W4-1:0] cnt_q;
  // stage 3
  logic          mode3_q, bad3_q;
  logic [LW-1:0] idx3_q;
  logic [DW-1:0] c3_0_q;
  logic [3:0]    used3_q;
  logic [W3-1:0] acc1_q;
  // stage 4
  logic          mode4_q, bad4_q;
  logic [3:0]    used4_q;
  logic [LW-1:0] work4_q;

  logic [DW-1:0] cin   [isc_pkg::SLOTS];
  logic [DW-1:0] czero [isc_pkg::SLOTS];
  logic [DW-1:0] seff  [isc_pkg::SLOTS];
  logic          oor_d;
  logic          cnt_bad_d;
  logic [W4-1:0] acc0_d;
  logic [LW-1:0] lin0_d;

  // stall chain: a stage loads when empty or when the next one moves
  assign rdy[3]    = !v_q[3] || out.ready;
  assign rdy[2]    = !v_q[2] || rdy[3];
  assign rdy[1]    = !v_q[1] || rdy[2];
  assign rdy[0]    = !v_q[0] || rdy[1];
  assign req.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= req.valid;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // stage 1: zero unused subscripts, check bounds, pair up extents
  assign cin[0] = req.coord0_in;
  assign cin[1] = req.coord1_in;
  assign cin[2] = req.coord2_in;
  assign cin[3] = req.coord3_in;

  always_comb begin
    oor_d = 1'b0;
    for (int k = 0; k < isc_pkg::SLOTS; k++) begin
      czero[k] = used_i[k] ? cin[k] : '0;
      seff[k]  = used_i[k] ? size_i[k] : DW'(1);
      if (used_i[k] && (cin[k] >= size_i[k])) oor_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mode1_q <= req.req_type;
      bad1_q  <= !req.req_type && oor_d;
      idx1_q  <= req.lin_index_in;
      c1_q    <= czero;
      used1_q <= used_i;
      p01_q   <= W2'(seff[0]) * W2'(seff[1]);
      p23_q   <= W2'(seff[2]) * W2'(seff[3]);
    end
  end

  // stage 2: element count, top Horner term
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      mode2_q <= mode1_q;
      bad2_q  <= bad1_q;
      idx2_q  <= idx1_q;
      c2_0_q  <= c1_q[0];
      c2_1_q  <= c1_q[1];
      used2_q <= used1_q;
      acc2_q  <= W2'(c1_q[3]) * W2'(size_i[2]) + W2'(c1_q[2]);
      cnt_q   <= W4'(p01_q) * W4'(p23_q);
    end
  end

  // stage 3: index bound check, next Horner term
  assign cnt_bad_d = mode2_q && (CW'(idx2_q) >= CW'(cnt_q));

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      mode3_q <= mode2_q;
      bad3_q  <= bad2_q || cnt_bad_d;
      idx3_q  <= idx2_q;
      c3_0_q  <= c2_0_q;
      used3_q <= used2_q;
      acc1_q  <= W3'(acc2_q) * W3'(size_i[1]) + W3'(c2_1_q);
    end
  end

  // stage 4: last Horner term, pick what the divider chain carries
  assign acc0_d = W4'(acc1_q) * W4'(size_i[0]) + W4'(c3_0_q);

  if (W4 >= LW) begin : g_lin_trunc
    assign lin0_d = acc0_d[LW-1:0];
  end else begin : g_lin_ext
    assign lin0_d = {{(LW - W4){1'b0}}, acc0_d};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      mode4_q <= mode3_q;
      bad4_q  <= bad3_q;
      used4_q <= used3_q;
      work4_q <= mode3_q ? idx3_q : lin0_d;
    end
  end

  assign out.valid = v_q[3];
  assign out.mode  = mode4_q;
  assign out.bad   = bad4_q;
  assign out.used  = used4_q;
  assign out.work  = work4_q;
  assign out.rem   = '0;

  always_comb begin
    for (int k = 0; k < isc_pkg::SLOTS; k++) begin
      out.coord[k] = '0;
    end
  end

endmodule

// ----- rtl/isc_div_stage.sv -----
// One stage of the restoring divider chain: resolves STEP_BITS quotient bits
// of the division by one extent. Depends on isc_pkg and isc_if.
module isc_div_stage #(
  parameter int unsigned DIM_BITS = isc_pkg::DEF_DIM_BITS,
  parameter int unsigned STEP     = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DIM_BITS-1:0] size_i [isc_pkg::SLOTS],
  isc_stage_if.sink           in,
  isc_stage_if.source         out
);

  localparam int unsigned DW    = DIM_BITS;
  localparam int unsigned LW    = isc_pkg::LIN_W;
  localparam int unsigned SPD   = LW / isc_pkg::STEP_BITS;
  localparam int unsigned DIM   = STEP / SPD;
  localparam bit          FIRST = (STEP % SPD) == 0;

  logic          v_q;
  logic          mode_q, bad_q;
  logic [3:0]    used_q;
  logic [LW-1:0] work_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] coord_q [isc_pkg::SLOTS];

  logic [LW-1:0] w_d;
  logic [DW-1:0] r_d;
  logic [DW:0]   t, diff;
  logic          ge;
  logic [DW-1:0] crd_d [isc_pkg::SLOTS];

  // shift in dividend bits, subtract the extent where it fits
  always_comb begin
    w_d = in.work;
    r_d = FIRST ? '0 : in.rem;
    t    = '0;
    diff = '0;
    ge   = 1'b0;
    for (int k = 0; k < isc_pkg::SLOTS; k++) begin
      crd_d[k] = (FIRST && (k + 1 == DIM)) ? in.rem : in.coord[k];
    end
    if (in.mode) begin
      for (int i = 0; i < isc_pkg::STEP_BITS; i++) begin
        t    = {r_d, w_d[LW-1]};
        diff = t - {1'b0, size_i[DIM]};
        ge   = t >= {1'b0, size_i[DIM]};
        w_d  = {w_d[LW-2:0], ge};
        r_d  = ge ? diff[DW-1:0] : t[DW-1:0];
      end
    end else begin
      r_d = in.rem;
    end
  end

  assign in.ready = !v_q || out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in.ready) begin
      v_q <= in.valid;
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (in.ready) begin
      mode_q  <= in.mode;
      bad_q   <= in.bad;
      used_q  <= in.used;
      work_q  <= w_d;
      rem_q   <= r_d;
      coord_q <= crd_d;
    end
  end

  assign out.valid = v_q;
  assign out.mode  = mode_q;
  assign out.bad   = bad_q;
  assign out.used  = used_q;
  assign out.work  = work_q;
  assign out.rem   = rem_q;
  assign out.coord = coord_q;

endmodule

// ----- rtl/index_subscript_converter.sv -----
// Top level of the index/subscript converter: configuration registers,
// front end, divider chain and output register. Depends on isc_pkg, isc_if,
// isc_front and isc_div_stage.
//
//   port    role      transfers
//   req     sink      one conversion request per transfer
//   rsp     source    one result per request, in request order
//   cfg_*   write     dimension count and extents, user writes while idle
//
// One request is taken per cycle while the chain has room; a result passes
// through four front-end stages (bounds, element count, Horner sum), 48
// divider stages (four quotient bits each, twelve per extent) and the output
// register. Reset clears all valid bits and sets one dimension of extent one.
// A stall on rsp fills empty stages first; requests keep flowing until the
// whole chain is full. The block does not enforce idle-only cfg writes.
module index_subscript_converter #(
  parameter int unsigned MAX_DIMS = isc_pkg::DEF_MAX_DIMS,
  parameter int unsigned DIM_BITS = isc_pkg::DEF_DIM_BITS,
  parameter int unsigned CFG_W    = (DIM_BITS > isc_pkg::NDIMS_W) ? DIM_BITS
                                                                   : isc_pkg::NDIMS_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [isc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  isc_req_if.sink                       req,
  isc_rsp_if.source                     rsp
);

  localparam int unsigned NW   = isc_pkg::NDIMS_W;
  localparam int unsigned NDIV = isc_pkg::SLOTS * (isc_pkg::LIN_W / isc_pkg::STEP_BITS);

  logic [NW-1:0]       num_dims_q;
  logic [DIM_BITS-1:0] size_q [isc_pkg::SLOTS];
  logic [NW-1:0]       n_eff;
  logic [isc_pkg::SLOTS-1:0] used;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= isc_pkg::NUM_DIMS_RST;
      for (int k = 0; k < isc_pkg::SLOTS; k++) begin
        size_q[k] <= DIM_BITS'(1);
      end
    end else if (cfg_we_i) begin
      unique case (isc_pkg::cfg_reg_e'(cfg_idx_i))
        isc_pkg::CFG_NUM_DIMS: num_dims_q <= cfg_data_i[NW-1:0];
        isc_pkg::CFG_SIZE0:    size_q[0]  <= cfg_data_i[DIM_BITS-1:0];
        isc_pkg::CFG_SIZE1:    size_q[1]  <= cfg_data_i[DIM_BITS-1:0];
        isc_pkg::CFG_SIZE2:    size_q[2]  <= cfg_data_i[DIM_BITS-1:0];
        isc_pkg::CFG_SIZE3:    size_q[3]  <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp the dimension count, then mark the slots in use
  always_comb begin
    if (num_dims_q == '0) begin
      n_eff = NW'(1);
    end else if (num_dims_q > NW'(MAX_DIMS)) begin
      n_eff = NW'(MAX_DIMS);
    end else begin
      n_eff = num_dims_q;
    end
    for (int k = 0; k < isc_pkg::SLOTS; k++) begin
      used[k] = NW'(k) < n_eff;
    end
  end

  isc_stage_if #(.DIM_BITS(DIM_BITS)) pipe [NDIV+1] ();

  isc_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .used_i (used),
    .size_i (size_q),
    .req    (req),
    .out    (pipe[0])
  );

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    isc_div_stage #(.DIM_BITS(DIM_BITS), .STEP(s)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .size_i (size_q),
      .in     (pipe[s]),
      .out    (pipe[s+1])
    );
  end

  // output register
  logic                      rsp_valid_q;
  logic [isc_pkg::LIN_W-1:0] lin_q;
  logic [DIM_BITS-1:0]       c0_q, c1_q, c2_q, c3_q;
  logic                      oor_q;
  logic                      ok_idx, ok_sub;

  assign pipe[NDIV].ready = !rsp_valid_q || rsp.ready;
  assign ok_idx = !pipe[NDIV].mode && !pipe[NDIV].bad;
  assign ok_sub =  pipe[NDIV].mode && !pipe[NDIV].bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (pipe[NDIV].ready) begin
      rsp_valid_q <= pipe[NDIV].valid;
    end
  end

  // zero everything but the flag on a bad request
  always_ff @(posedge clk_i) begin
    if (pipe[NDIV].ready) begin
      lin_q <= ok_idx ? pipe[NDIV].work : '0;
      c0_q  <= (ok_sub && pipe[NDIV].used[0]) ? pipe[NDIV].coord[0] : '0;
      c1_q  <= (ok_sub && pipe[NDIV].used[1]) ? pipe[NDIV].coord[1] : '0;
      c2_q  <= (ok_sub && pipe[NDIV].used[2]) ? pipe[NDIV].coord[2] : '0;
      c3_q  <= (ok_sub && pipe[NDIV].used[3]) ? pipe[NDIV].rem      : '0;
      oor_q <= pipe[NDIV].bad;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.lin_index_out = lin_q;
  assign rsp.coord0_out    = c0_q;
  assign rsp.coord1_out    = c1_q;
  assign rsp.coord2_out    = c2_q;
  assign rsp.coord3_out    = c3_q;
  assign rsp.out_of_range  = oor_q;

endmodule
